FILE: hw/rtl/cafu_pkg.sv
// Package for the CPU ALU flag unit: operation codes and flag bit positions.
`default_nettype none

package cafu_pkg;

  // Operation codes carried in the command field.
  typedef enum logic [4:0] {
    CMD_ADD   = 5'd0,
    CMD_ADC   = 5'd1,
    CMD_SUB   = 5'd2,
    CMD_SBC   = 5'd3,
    CMD_AND   = 5'd4,
    CMD_OR    = 5'd5,
    CMD_XOR   = 5'd6,
    CMD_CP    = 5'd7,
    CMD_INC   = 5'd8,
    CMD_DEC   = 5'd9,
    CMD_SWAP  = 5'd10,
    CMD_CPL   = 5'd11,
    CMD_CCF   = 5'd12,
    CMD_SCF   = 5'd13,
    CMD_RLCA  = 5'd14,
    CMD_ADDHL = 5'd15,
    CMD_ADDSP = 5'd16,
    CMD_INC16 = 5'd17,
    CMD_DEC16 = 5'd18
  } alu_cmd_t;

  // Bit positions inside the 4-bit flag word.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

endpackage

`default_nettype wire

FILE: hw/rtl/cpu_alu_flag_unit.sv
// Top level of the CPU ALU flag unit: input register, flag logic, result register.
// The unit takes one operation per clock while not stalled and returns its result through
// the input register, where the adders and flag logic work, and the result register
// that drives the output. When the output is
// stalled, both registers hold and in_stall rises once both are full, so a full
// pipeline still moves one item per cycle as soon as the stall drops.
`default_nettype none

module cpu_alu_flag_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  command,
  input  wire logic [15:0] operand_a,
  input  wire logic [15:0] operand_b,
  input  wire logic [3:0]  flags_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      result_value,
  output logic [3:0]       flags_out
);

  // Input register stage.
  logic        s1_valid;
  logic [4:0]  s1_command;
  logic [15:0] s1_op_a;
  logic [15:0] s1_op_b;
  logic [3:0]  s1_flags;

  // Stage control: the result register loads when empty or being drained.
  logic s2_load;
  logic s1_load;

  assign s2_load  = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_command <= command;
      s1_op_a    <= operand_a;
      s1_op_b    <= operand_b;
      s1_flags   <= flags_in;
    end
  end

  // Operand slices and adders for the arithmetic operations.
  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        cin;
  logic        t_add;
  logic        t_sub;
  logic [8:0]  add9;
  logic [4:0]  addh5;
  logic [8:0]  sub9;
  logic [4:0]  subh5;
  logic [16:0] hl17;
  logic [12:0] hlh13;
  logic [15:0] sp16;
  logic [8:0]  spc9;
  logic [4:0]  sph5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;

  assign a8    = s1_op_a[7:0];
  assign b8    = s1_op_b[7:0];
  assign cin   = s1_flags[cafu_pkg::FLAG_C];
  assign t_add = (s1_command == cafu_pkg::CMD_ADC) && cin;
  assign t_sub = (s1_command == cafu_pkg::CMD_SBC) && cin;
  assign add9  = {1'b0, a8} + {1'b0, b8} + {8'd0, t_add};
  assign addh5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, t_add};
  assign sub9  = {1'b0, a8} - {1'b0, b8} - {8'd0, t_sub};
  assign subh5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, t_sub};
  assign hl17  = {1'b0, s1_op_a} + {1'b0, s1_op_b};
  assign hlh13 = {1'b0, s1_op_a[11:0]} + {1'b0, s1_op_b[11:0]};
  assign sp16  = s1_op_a + {{8{b8[7]}}, b8};
  assign spc9  = {1'b0, s1_op_a[7:0]} + {1'b0, b8};
  assign sph5  = {1'b0, s1_op_a[3:0]} + {1'b0, b8[3:0]};
  assign inc8  = b8 + 8'd1;
  assign dec8  = b8 - 8'd1;

  // Result and flag selection by operation.
  logic [15:0] res_next;
  logic [3:0]  flg_next;

  always_comb begin
    res_next = s1_op_a;
    flg_next = s1_flags;
    case (cafu_pkg::alu_cmd_t'(s1_command))
      cafu_pkg::CMD_ADD, cafu_pkg::CMD_ADC: begin
        res_next = {8'd0, add9[7:0]};
        flg_next = {add9[7:0] == 8'd0, 1'b0, addh5[4], add9[8]};
      end
      cafu_pkg::CMD_SUB, cafu_pkg::CMD_SBC: begin
        res_next = {8'd0, sub9[7:0]};
        flg_next = {sub9[7:0] == 8'd0, 1'b1, subh5[4], sub9[8]};
      end
      cafu_pkg::CMD_CP: begin
        flg_next = {sub9[7:0] == 8'd0, 1'b1, subh5[4], sub9[8]};
      end
      cafu_pkg::CMD_AND: begin
        res_next = {8'd0, a8 & b8};
        flg_next = {(a8 & b8) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      cafu_pkg::CMD_OR: begin
        res_next = {8'd0, a8 | b8};
        flg_next = {(a8 | b8) == 8'd0, 3'b000};
      end
      cafu_pkg::CMD_XOR: begin
        res_next = {8'd0, a8 ^ b8};
        flg_next = {(a8 ^ b8) == 8'd0, 3'b000};
      end
      cafu_pkg::CMD_INC: begin
        res_next = {8'd0, inc8};
        flg_next = {inc8 == 8'd0, 1'b0, b8[3:0] == 4'hF, cin};
      end
      cafu_pkg::CMD_DEC: begin
        res_next = {8'd0, dec8};
        flg_next = {dec8 == 8'd0, 1'b1, b8[3:0] == 4'h0, cin};
      end
      cafu_pkg::CMD_SWAP: begin
        res_next = {8'd0, b8[3:0], b8[7:4]};
        flg_next = {b8 == 8'd0, 3'b000};
      end
      cafu_pkg::CMD_CPL: begin
        res_next = {8'd0, ~a8};
        flg_next = {s1_flags[cafu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
      end
      cafu_pkg::CMD_CCF: begin
        flg_next = {s1_flags[cafu_pkg::FLAG_Z], 1'b0, 1'b0, !cin};
      end
      cafu_pkg::CMD_SCF: begin
        flg_next = {s1_flags[cafu_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1};
      end
      cafu_pkg::CMD_RLCA: begin
        res_next = {8'd0, a8[6:0], a8[7]};
        flg_next = {3'b000, a8[7]};
      end
      cafu_pkg::CMD_ADDHL: begin
        res_next = hl17[15:0];
        flg_next = {s1_flags[cafu_pkg::FLAG_Z], 1'b0, hlh13[12], hl17[16]};
      end
      cafu_pkg::CMD_ADDSP: begin
        res_next = sp16;
        flg_next = {2'b00, sph5[4], spc9[8]};
      end
      cafu_pkg::CMD_INC16: begin
        res_next = s1_op_a + 16'd1;
      end
      cafu_pkg::CMD_DEC16: begin
        res_next = s1_op_a - 16'd1;
      end
      default: begin
        // Unused codes pass the operand and flags through.
        res_next = s1_op_a;
        flg_next = s1_flags;
      end
    endcase
  end

  // Result register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      result_value <= res_next;
      flags_out    <= flg_next;
    end
  end

  // An accepted item always lands in the input register.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted item did not reach the input register");

  // A held item in the input register moves on when the result register frees up.
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_load |=> out_valid)
    else $error("item lost between the input and result registers");

  // The input side is stalled only when both registers are full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // A compare returns its first operand unchanged.
  a_cp_passes: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_load && (s1_command == cafu_pkg::CMD_CP)
    |=> result_value == $past(s1_op_a))
    else $error("compare changed the operand");

endmodule

`default_nettype wire
